>>> sv/rbw_pkg.sv
`default_nettype none

package rbw_pkg;

  // Field and register widths
  localparam int TIME_W      = 32;
  localparam int CMD_W       = 2;
  localparam int WINDOW_W    = 27;
  localparam int MAXEXP_W    = 5;
  localparam int COUNT_OUT_W = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = WINDOW_W;

  // Defaults and constants
  localparam int HISTORY_DEPTH_DEF = 32;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(60000);
  localparam logic [MAXEXP_W-1:0] MAXEXP_RST = MAXEXP_W'(5);
  localparam int BACKOFF_UNIT    = 1000;
  // Largest exponent whose backoff still fits in a 32-bit age
  localparam int BACKOFF_MAX_EXP = 22;
  localparam int COUNT_SAT       = 63;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_MAXEXP = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALW_ZERO = 2'd0,
    ALW_ONE  = 2'd1,
    ALW_CMP  = 2'd2
  } alw_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_DECIDE,
    ST_NEWEST_CHK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     rd_head;
    logic     rd_newest;
    logic     pop;
    logic     record;
    logic     clear;
    logic     alw_load;
    alw_sel_t alw_sel;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_code_t code;
    logic      count_zero;
    logic      stale;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> sv/rbw_dp.sv
`default_nettype none

module rbw_dp #(
  parameter int HISTORY_DEPTH = rbw_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  [rbw_pkg::CMD_W-1:0]          in_command,
  input  wire  [rbw_pkg::TIME_W-1:0]         in_now_ms,
  input  wire                                cfg_we,
  input  wire  [rbw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [rbw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  rbw_pkg::ctrl_cmd_t                 cmd,
  output rbw_pkg::ctrl_sts_t                 sts,
  output logic                               out_allowed,
  output logic [rbw_pkg::COUNT_OUT_W-1:0]    out_stored_count
);
  import rbw_pkg::*;

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int SAT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam int CMPW  = (CNT_W > MAXEXP_W) ? CNT_W : MAXEXP_W;

  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(HISTORY_DEPTH - 1);

  logic [TIME_W-1:0]   mem [HISTORY_DEPTH];
  logic [TIME_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [WINDOW_W-1:0] window_r;
  logic [MAXEXP_W-1:0] maxexp_r;
  cmd_code_t           code_r;
  logic [TIME_W-1:0]   now_r;
  logic                alw_r;
  logic                out_allowed_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic [IDX_W-1:0]    head_inc;
  logic [SUM_W-1:0]    newest_sum, tail_sum;
  logic [IDX_W-1:0]    newest_ix, tail_ix, rd_addr, wr_addr;
  logic                full;
  logic [TIME_W-1:0]   age;
  logic [MAXEXP_W-1:0] exp_n;
  logic [TIME_W:0]     backoff;
  logic                alw_cmp;
  logic [SAT_W-1:0]    count_ext;
  logic [COUNT_OUT_W-1:0] count_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      maxexp_r <= MAXEXP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW: window_r <= cfg_wdata;
        REG_MAXEXP: maxexp_r <= cfg_wdata[MAXEXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the request while it is worked on
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r <= cmd_code_t'(in_command);
      now_r  <= in_now_ms;
    end
  end

  // Ring addresses
  always_comb begin
    head_inc   = (head_r == LAST_IX) ? '0 : head_r + IDX_W'(1);
    newest_sum = SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(1);
    if (newest_sum >= DEPTH_S) newest_sum = newest_sum - DEPTH_S;
    tail_sum   = SUM_W'(head_r) + SUM_W'(count_r);
    if (tail_sum >= DEPTH_S) tail_sum = tail_sum - DEPTH_S;
    newest_ix  = newest_sum[IDX_W-1:0];
    tail_ix    = tail_sum[IDX_W-1:0];
    full       = (count_r == DEPTH_C);
    rd_addr    = cmd.rd_newest ? newest_ix : head_r;
    wr_addr    = full ? head_r : tail_ix;
  end

  // Timestamp memory
  always_ff @(posedge clk) begin
    if (cmd.record) mem[wr_addr] <= now_r;
    if (cmd.rd_head || cmd.rd_newest) rd_data_r <= mem[rd_addr];
  end

  // Head pointer and fill count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.record) begin
      if (full) head_nxt = head_inc;
      else      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Age of the entry just read, and the backoff test on it
  always_comb begin
    age = now_r - rd_data_r;
    if (CMPW'(count_r) > CMPW'(maxexp_r)) exp_n = maxexp_r;
    else                                  exp_n = MAXEXP_W'(count_r);
    backoff = (TIME_W + 1)'(BACKOFF_UNIT) << exp_n;
    alw_cmp = (exp_n <= MAXEXP_W'(BACKOFF_MAX_EXP)) && ({1'b0, age} >= backoff);
  end

  assign sts.code       = code_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.stale      = (age > TIME_W'(window_r));

  // Allowed flag for the pending result
  always_ff @(posedge clk) begin
    if (cmd.alw_load) begin
      case (cmd.alw_sel)
        ALW_ONE: alw_r <= 1'b1;
        ALW_CMP: alw_r <= alw_cmp;
        default: alw_r <= 1'b0;
      endcase
    end
  end

  // Result register, count saturated to the field
  always_comb begin
    count_ext = SAT_W'(count_r);
    count_sat = (count_ext > SAT_W'(COUNT_SAT)) ? COUNT_OUT_W'(COUNT_SAT)
                                                : count_ext[COUNT_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_allowed_r <= alw_r;
      out_count_r   <= count_sat;
    end
  end

  assign out_allowed      = out_allowed_r;
  assign out_stored_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("fill count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_IX) else $error("head pointer beyond depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0) else $error("clear left entries");

endmodule

`default_nettype wire

>>> sv/rbw_ctrl.sv
`default_nettype none

module rbw_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  rbw_pkg::ctrl_sts_t  sts,
  output rbw_pkg::ctrl_cmd_t  cmd
);
  import rbw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one request: prune, decide, present result
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PRUNE_RD;
        end
      end
      ST_PRUNE_RD: begin
        if (sts.code == CMD_CLEAR || sts.code == CMD_NOP || sts.count_zero) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = ST_PRUNE_CHK;
        end
      end
      ST_PRUNE_CHK: begin
        if (sts.stale) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_PRUNE_RD;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.alw_load = 1'b1;
        cmd.alw_sel  = ALW_ZERO;
        state_nxt    = ST_RESULT;
        unique case (sts.code)
          CMD_CHECK: begin
            if (sts.count_zero) begin
              cmd.alw_sel = ALW_ONE;
            end else begin
              cmd.alw_load  = 1'b0;
              cmd.rd_newest = 1'b1;
              state_nxt     = ST_NEWEST_CHK;
            end
          end
          CMD_RECORD: cmd.record = 1'b1;
          CMD_CLEAR:  cmd.clear  = 1'b1;
          default: ;
        endcase
      end
      ST_NEWEST_CHK: begin
        cmd.alw_load = 1'b1;
        cmd.alw_sel  = ALW_CMP;
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)              out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_PRUNE_RD)
    else $error("accepted request did not start pruning");

  a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised outside result state");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before it was taken");

endmodule

`default_nettype wire

>>> sv/retry_backoff_window.sv
// Channel | Handshake                | Payload
// in      | in_valid / in_ready      | in_command, in_now_ms
// out     | out_valid / out_ready    | out_allowed, out_stored_count
// cfg     | cfg_we (no wait)         | cfg_index, cfg_wdata
//
// One request at a time. A clear, the unused code or a request that finds the
// history empty passes through accept, prune read, decide and result. Each pruned
// entry adds a read and a compare, a surviving oldest entry adds its compare, and
// a check with entries left adds the read of the newest entry.
// Reset (synchronous, rst_n low) empties the history and restores the
// configuration defaults; memory contents are not cleared.
// A finished result waits in the output register; a new request is taken
// meanwhile, and only its own result waits on out_ready.
`default_nettype none

module retry_backoff_window #(
  parameter int HISTORY_DEPTH = rbw_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [rbw_pkg::CMD_W-1:0]        in_command,
  input  wire  [rbw_pkg::TIME_W-1:0]       in_now_ms,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_allowed,
  output logic [rbw_pkg::COUNT_OUT_W-1:0]  out_stored_count,
  input  wire                              cfg_we,
  input  wire  [rbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [rbw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rbw_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  rbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // History, configuration and result datapath
  rbw_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_now_ms        (in_now_ms),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_allowed      (out_allowed),
    .out_stored_count (out_stored_count)
  );

endmodule

`default_nettype wire
